// ----- design/sai_pkg.sv -----
// shared types and constants for the sorted table with insert, delete and dump
// no dependencies

package sai_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 6;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_DELETE = 2'd2,
    CM_ROTATE = 2'd3
  } cell_mode_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    cell_mode_t               mode;
    logic [CNT_W-1:0]         count;
    logic [IDX_W-1:0]         pos;
    logic signed [WORD_W-1:0] value;
  } cell_ctl_t;

endpackage

// ----- design/sorted_array_insert_delete.sv -----
// top level: sorted table of signed words held in a row of compare-and-shift
// cells, with the command decoder, dump sequencer and result register
// depends on sai_pkg and sai_cell
//
//   port group                    dir  transfer
//   start opcode value position   in   start high while busy low
//   strobe status data index      out  strobe high for one cycle, no stall
//     count last
//
// insert, delete and the unused opcode leave busy low; a new command may be
// given in the very next cycle. the result shows in the cycle after the command.
// a dump of n entries holds busy while the row rotates once past cell 0,
// one result a cycle; an empty dump gives one result.
// reset clears the count, the sequencer and the strobe; cell words are not reset.

module sorted_array_insert_delete #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [sai_pkg::OP_W-1:0]          opcode,
  input  logic signed [sai_pkg::WORD_W-1:0] value,
  input  logic [sai_pkg::IDX_W-1:0]         position,
  output logic                              strobe,
  output logic [sai_pkg::ST_W-1:0]          status,
  output logic signed [sai_pkg::WORD_W-1:0] data,
  output logic [sai_pkg::IDX_W-1:0]         index,
  output logic [sai_pkg::CNT_W-1:0]         count,
  output logic                              last
);

  localparam logic [sai_pkg::CNT_W-1:0] DEPTH_C = DEPTH[sai_pkg::CNT_W-1:0];

  sai_pkg::state_t state, state_next;
  logic [sai_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [sai_pkg::IDX_W-1:0] dump_idx, dump_idx_next;
  logic                      dump_end;

  logic                              strobe_next;
  sai_pkg::status_t                  status_next;
  logic signed [sai_pkg::WORD_W-1:0] data_next;
  logic [sai_pkg::IDX_W-1:0]         index_next;
  logic [sai_pkg::CNT_W-1:0]         count_next;
  logic                              last_next;

  sai_pkg::cell_ctl_t ctl;

  logic signed [sai_pkg::WORD_W-1:0] words [DEPTH];
  logic                              takes [DEPTH];

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [sai_pkg::WORD_W-1:0] left_w;
      logic                              left_t;
      logic signed [sai_pkg::WORD_W-1:0] right_w;
      if (g == 0) begin : g_first
        assign left_w = words[0];
        assign left_t = 1'b0;
      end else begin : g_mid
        assign left_w = words[g-1];
        assign left_t = takes[g-1];
      end
      if (g == DEPTH - 1) begin : g_end
        assign right_w = words[g];
      end else begin : g_inner
        assign right_w = words[g+1];
      end
      sai_cell #(
        .IDX(g)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .left_word (left_w),
        .left_take (left_t),
        .right_word(right_w),
        .head_word (words[0]),
        .take      (takes[g]),
        .word      (words[g])
      );
    end
  endgenerate

  assign busy     = state == sai_pkg::S_DUMP;
  assign dump_end = ({1'b0, dump_idx} + 7'd1) == cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sai_pkg::S_IDLE;
      cnt      <= '0;
      dump_idx <= '0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      dump_idx <= dump_idx_next;
      strobe   <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    data   <= data_next;
    index  <= index_next;
    count  <= count_next;
    last   <= last_next;
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    dump_idx_next = dump_idx;
    strobe_next   = 1'b0;
    status_next   = sai_pkg::ST_OK;
    data_next     = '0;
    index_next    = '0;
    count_next    = cnt;
    last_next     = 1'b1;
    ctl.mode      = sai_pkg::CM_HOLD;
    ctl.count     = cnt;
    ctl.pos       = position;
    ctl.value     = value;
    case (state)
      sai_pkg::S_IDLE: begin
        if (start) begin
          strobe_next = 1'b1;
          case (sai_pkg::op_t'(opcode))
            sai_pkg::OP_INSERT: begin
              if (cnt >= DEPTH_C) begin
                status_next = sai_pkg::ST_FULL;
              end else begin
                ctl.mode   = sai_pkg::CM_INSERT;
                cnt_next   = cnt + 7'd1;
                count_next = cnt + 7'd1;
              end
            end
            sai_pkg::OP_DELETE: begin
              if ({1'b0, position} >= cnt) begin
                status_next = sai_pkg::ST_BADPOS;
              end else begin
                ctl.mode   = sai_pkg::CM_DELETE;
                cnt_next   = cnt - 7'd1;
                count_next = cnt - 7'd1;
              end
            end
            sai_pkg::OP_DUMP: begin
              if (cnt == '0) begin
                status_next = sai_pkg::ST_EMPTY;
              end else begin
                // results come from the dump cycles
                strobe_next   = 1'b0;
                dump_idx_next = '0;
                state_next    = sai_pkg::S_DUMP;
              end
            end
            default: begin
              status_next = sai_pkg::ST_OK;
            end
          endcase
        end
      end
      sai_pkg::S_DUMP: begin
        // cell 0 shows the next entry; the row rotates so it is whole again at the end
        ctl.mode      = sai_pkg::CM_ROTATE;
        strobe_next   = 1'b1;
        data_next     = words[0];
        index_next    = dump_idx;
        last_next     = dump_end;
        dump_idx_next = dump_idx + 6'd1;
        if (dump_end) begin
          state_next = sai_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sai_pkg::S_IDLE;
      end
    endcase
  end

  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == sai_pkg::S_DUMP) |-> (cnt != '0) && ({1'b0, dump_idx} < cnt))
    else $error("dump running past the held entries");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= DEPTH_C)
    else $error("entry count above table depth");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("dump burst broken before its last result");

  a_command_answered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode != sai_pkg::OP_DUMP)) |=> (strobe && last))
    else $error("command without a single result");

endmodule

// ----- design/sai_cell.sv -----
// one storage cell of the sorted row: holds a word, compares it with the broadcast
// value and takes a neighbour's word, the new value or the head word on insert, delete or rotate
// depends on sai_pkg

module sai_cell #(
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  sai_pkg::cell_ctl_t                ctl,
  input  logic signed [sai_pkg::WORD_W-1:0] left_word,
  input  logic                              left_take,
  input  logic signed [sai_pkg::WORD_W-1:0] right_word,
  input  logic signed [sai_pkg::WORD_W-1:0] head_word,
  output logic                              take,
  output logic signed [sai_pkg::WORD_W-1:0] word
);

  localparam logic [sai_pkg::CNT_W-1:0] IDX_C = IDX[sai_pkg::CNT_W-1:0];

  logic occupied;
  logic is_tail;
  logic pos_hit;
  logic signed [sai_pkg::WORD_W-1:0] word_next;

  assign occupied = IDX_C < ctl.count;
  assign is_tail  = (IDX_C + 7'd1) == ctl.count;
  assign pos_hit  = IDX_C >= {1'b0, ctl.pos};

  // free cells count as larger than anything, so a value no smaller than every held word lands at the end
  assign take = occupied ? (word > ctl.value) : 1'b1;

  always_comb begin
    word_next = word;
    case (ctl.mode)
      sai_pkg::CM_INSERT: begin
        if (take) begin
          word_next = left_take ? left_word : ctl.value;
        end
      end
      sai_pkg::CM_DELETE: begin
        if (pos_hit) begin
          word_next = right_word;
        end
      end
      sai_pkg::CM_ROTATE: begin
        if (occupied) begin
          word_next = is_tail ? head_word : right_word;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule
